FILE: src/rms_pkg.sv
// Shared types and constants for the robot mode sequencer.
// Used by rms_core and robot_mode_sequencer; no dependencies.
package rms_pkg;

    localparam logic [2:0] MODE_START   = 3'd0;
    localparam logic [2:0] MODE_CENTER  = 3'd1;
    localparam logic [2:0] MODE_STALL   = 3'd2;
    localparam logic [2:0] MODE_SEARCH  = 3'd3;
    localparam logic [2:0] MODE_REVERSE = 3'd4;
    localparam logic [2:0] MODE_CHASE   = 3'd5;

    localparam logic signed [7:0] DRIVE_STOP = 8'sd0;
    localparam logic signed [7:0] DRIVE_FAST = 8'sd75;
    localparam logic signed [7:0] DRIVE_BACK = -8'sd75;
    localparam logic signed [7:0] DRIVE_TURN = 8'sd30;

    localparam logic [1:0] REG_START_DELAY  = 2'd0;
    localparam logic [1:0] REG_REVERSE_TIME = 2'd1;
    localparam logic [1:0] REG_CENTER_TIME  = 2'd2;
    localparam logic [1:0] REG_DETECT_RANGE = 2'd3;

    localparam logic [15:0] START_DELAY_RST  = 16'd500;
    localparam logic [15:0] REVERSE_TIME_RST = 16'd500;
    localparam logic [15:0] CENTER_TIME_RST  = 16'd500;
    localparam logic [9:0]  DETECT_RANGE_RST = 10'd30;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        line;
        logic [9:0]  dist_left;
        logic [9:0]  dist_right;
    } t_item;

    typedef struct packed {
        logic [15:0] start_delay_ms;
        logic [15:0] reverse_time_ms;
        logic [15:0] center_time_ms;
        logic [9:0]  detect_range;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        mode;
        logic              wait_armed;
        logic [31:0]       wait_begin;
        logic              last_turn_right;
        logic signed [7:0] left_cmd;
        logic signed [7:0] right_cmd;
        logic              magnet;
    } t_state;

endpackage

FILE: src/rms_core.sv
// Mode state registers and the per-tick decision logic (one tick per step).
// Depends on rms_pkg.
module rms_core
    import rms_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_step,
    input  t_item  i_item,
    input  t_cfg   i_cfg,
    output t_state o_state,
    output t_state o_next
);

    t_state      r_st;
    t_state      n_st;
    logic        det_l;
    logic        det_r;
    logic [31:0] elapsed;
    logic [15:0] span;
    logic        use_wait;
    logic        over;
    logic        fired;

    assign det_l   = i_item.dist_left  < i_cfg.detect_range;
    assign det_r   = i_item.dist_right < i_cfg.detect_range;
    assign elapsed = i_item.now_ms - r_st.wait_begin;
    assign over    = elapsed > {16'd0, span};
    assign fired   = use_wait && r_st.wait_armed && over;

    // Which wait span the current mode uses, and whether it polls the timer.
    always_comb begin
        span     = i_cfg.start_delay_ms;
        use_wait = 1'b0;
        case (r_st.mode)
            MODE_START: begin
                span     = i_cfg.start_delay_ms;
                use_wait = 1'b1;
            end
            MODE_CENTER: begin
                span     = i_cfg.center_time_ms;
                use_wait = !i_item.line;
            end
            MODE_REVERSE: begin
                span     = i_cfg.reverse_time_ms;
                use_wait = 1'b1;
            end
            default: begin
                span     = i_cfg.start_delay_ms;
                use_wait = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_st = r_st;
        // shared timer: arm on first poll, disarm when it fires
        if (use_wait) begin
            if (!r_st.wait_armed) begin
                n_st.wait_armed = 1'b1;
                n_st.wait_begin = i_item.now_ms;
            end else if (over) begin
                n_st.wait_armed = 1'b0;
            end
        end
        case (r_st.mode)
            MODE_START: begin
                n_st.left_cmd  = DRIVE_STOP;
                n_st.right_cmd = DRIVE_STOP;
                if (fired) begin
                    n_st.mode = MODE_CENTER;
                end
            end
            MODE_CENTER: begin
                n_st.left_cmd  = DRIVE_FAST;
                n_st.right_cmd = DRIVE_FAST;
                if (i_item.line) begin
                    n_st.mode = MODE_REVERSE;
                end else if (fired) begin
                    n_st.left_cmd  = DRIVE_STOP;
                    n_st.right_cmd = DRIVE_STOP;
                    n_st.mode      = (det_l && det_r) ? MODE_CHASE : MODE_SEARCH;
                end
            end
            MODE_STALL: begin
                n_st.left_cmd  = DRIVE_STOP;
                n_st.right_cmd = DRIVE_STOP;
                n_st.magnet    = 1'b1;
            end
            MODE_SEARCH: begin
                if (i_item.line) begin
                    n_st.mode = MODE_STALL;
                end else if (det_l && det_r) begin
                    n_st.mode = MODE_CHASE;
                end else begin
                    if (det_r) begin
                        n_st.last_turn_right = 1'b1;
                    end else if (det_l) begin
                        n_st.last_turn_right = 1'b0;
                    end
                    if (n_st.last_turn_right) begin
                        n_st.left_cmd  = DRIVE_TURN;
                        n_st.right_cmd = -DRIVE_TURN;
                    end else begin
                        n_st.left_cmd  = -DRIVE_TURN;
                        n_st.right_cmd = DRIVE_TURN;
                    end
                end
            end
            MODE_REVERSE: begin
                n_st.left_cmd  = DRIVE_BACK;
                n_st.right_cmd = DRIVE_BACK;
                if (fired) begin
                    n_st.left_cmd  = DRIVE_STOP;
                    n_st.right_cmd = DRIVE_STOP;
                    n_st.mode      = MODE_SEARCH;
                end
            end
            MODE_CHASE: begin
                n_st.left_cmd  = DRIVE_FAST;
                n_st.right_cmd = DRIVE_FAST;
                if (i_item.line) begin
                    n_st.mode = MODE_REVERSE;
                end else if (!det_r || !det_l) begin
                    n_st.mode = MODE_SEARCH;
                end
            end
            default: begin
                n_st = r_st;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode            <= MODE_START;
            r_st.wait_armed      <= 1'b0;
            r_st.wait_begin      <= 32'd0;
            r_st.last_turn_right <= 1'b1;
            r_st.left_cmd        <= DRIVE_STOP;
            r_st.right_cmd       <= DRIVE_STOP;
            r_st.magnet          <= 1'b0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    assign o_state = r_st;
    assign o_next  = n_st;

endmodule

FILE: src/robot_mode_sequencer.sv
// A request accepted into the input register is decided and loaded into the result register
// once the result register is empty or being taken; a held-off output holds it there.
// Throughput: one tick per cycle while the output is taken; the input register, the decision logic and the result
// register form one pass, and the next tick needs only the state this one writes.
// Reset (synchronous, active low) returns the mode to start, disarms the wait timer,
// zeroes the motor commands and magnet, and loads the register defaults.
module robot_mode_sequencer
    import rms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [31:0]       i_now_ms,
    input  logic              i_line_front_a,
    input  logic              i_line_front_b,
    input  logic [9:0]        i_dist_left,
    input  logic [9:0]        i_dist_right,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [7:0] o_drive_left,
    output logic signed [7:0] o_drive_right,
    output logic              o_magnet_on,
    output logic [2:0]        o_mode_now,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    t_cfg   r_cfg;
    logic   r_in_valid;
    t_item  r_in;
    logic   r_out_valid;
    t_state r_out;
    t_state core_state;
    t_state core_next;
    logic   advance;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_delay_ms  <= START_DELAY_RST;
            r_cfg.reverse_time_ms <= REVERSE_TIME_RST;
            r_cfg.center_time_ms  <= CENTER_TIME_RST;
            r_cfg.detect_range    <= DETECT_RANGE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START_DELAY:  r_cfg.start_delay_ms  <= i_cfg_data;
                REG_REVERSE_TIME: r_cfg.reverse_time_ms <= i_cfg_data;
                REG_CENTER_TIME:  r_cfg.center_time_ms  <= i_cfg_data;
                REG_DETECT_RANGE: r_cfg.detect_range    <= i_cfg_data[9:0];
                default:          r_cfg                 <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in.now_ms     <= i_now_ms;
            r_in.line       <= i_line_front_a | i_line_front_b;
            r_in.dist_left  <= i_dist_left;
            r_in.dist_right <= i_dist_right;
        end
    end

    rms_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_state (core_state),
        .o_next  (core_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_next;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_drive_left  = r_out.left_cmd;
    assign o_drive_right = r_out.right_cmd;
    assign o_magnet_on   = r_out.magnet;
    assign o_mode_now    = r_out.mode;

`ifndef NO_ASSERTIONS
    // once energized, the magnet stays on until reset
    a_magnet_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_state.magnet |=> core_state.magnet)
        else $error("magnet dropped without reset");

    // a tick spent in stall energizes the magnet
    a_stall_magnet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && core_state.mode == MODE_STALL) |=> core_state.magnet)
        else $error("stall tick left the magnet off");

    // an empty result register never holds back the input side
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while result register empty");

    // the state advances only when a result is loaded
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(core_state))
        else $error("state changed without a request");
`endif

endmodule

FILE: sim/robot_mode_sequencer_test.sv
// Self-checking testbench for robot_mode_sequencer: directed mode walks, then randomized ticks
// under several register settings, each result checked against an in-bench sequencer model.
// Depends on rms_pkg and robot_mode_sequencer.
module robot_mode_sequencer_test;
    import rms_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_TICKS   = 370;

    typedef struct packed {
        logic signed [7:0] drv_left;
        logic signed [7:0] drv_right;
        logic              magnet;
        logic [2:0]        mode;
    } t_drive_state;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [31:0]       i_now_ms;
    logic              i_line_front_a;
    logic              i_line_front_b;
    logic [9:0]        i_dist_left;
    logic [9:0]        i_dist_right;
    logic              o_valid;
    logic              i_ready;
    logic signed [7:0] o_drive_left;
    logic signed [7:0] o_drive_right;
    logic              o_magnet_on;
    logic [2:0]        o_mode_now;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [15:0]       i_cfg_data;

    // sequencer model state and registers, reset values
    logic [2:0]        seq_mode   = MODE_START;
    logic              tmr_armed  = 1'b0;
    logic [31:0]       tmr_begin  = 32'd0;
    logic              turn_right = 1'b1;
    logic signed [7:0] seq_left   = DRIVE_STOP;
    logic signed [7:0] seq_right  = DRIVE_STOP;
    logic              seq_magnet = 1'b0;
    logic [15:0]       cfg_start_delay  = START_DELAY_RST;
    logic [15:0]       cfg_reverse_time = REVERSE_TIME_RST;
    logic [15:0]       cfg_center_time  = CENTER_TIME_RST;
    logic [9:0]        cfg_detect_range = DETECT_RANGE_RST;

    t_drive_state expected_drive[$];
    logic [31:0]  clock_ms = 32'd0;
    bit           idle_bursts = 1'b1;
    int           hold_cycles = 0;
    int           error_count = 0;
    int unsigned  cycle_count = 0;

    robot_mode_sequencer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_now_ms       (i_now_ms),
        .i_line_front_a (i_line_front_a),
        .i_line_front_b (i_line_front_b),
        .i_dist_left    (i_dist_left),
        .i_dist_right   (i_dist_right),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_drive_left   (o_drive_left),
        .o_drive_right  (o_drive_right),
        .o_magnet_on    (o_magnet_on),
        .o_mode_now     (o_mode_now),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        // cap the log, keep counting
        if (error_count < 50) $display("mismatch: %s", msg);
        error_count++;
    endtask

    // shared wait timer: arms on first call, fires when elapsed time exceeds span
    function automatic logic timer_expired(input logic [31:0] now, input logic [15:0] span);
        logic [31:0] elapsed;
        if (!tmr_armed) begin
            tmr_armed = 1'b1;
            tmr_begin = now;
            return 1'b0;
        end
        elapsed = now - tmr_begin;
        if (elapsed > {16'd0, span}) begin
            tmr_armed = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void advance_sequencer(input logic [31:0] now, input logic line,
                                              input logic [9:0] dist_l,
                                              input logic [9:0] dist_r);
        logic near_l;
        logic near_r;
        near_l = dist_l < cfg_detect_range;
        near_r = dist_r < cfg_detect_range;
        case (seq_mode)
            MODE_START: begin
                seq_left  = DRIVE_STOP;
                seq_right = DRIVE_STOP;
                if (timer_expired(now, cfg_start_delay)) seq_mode = MODE_CENTER;
            end
            MODE_CENTER: begin
                seq_left  = DRIVE_FAST;
                seq_right = DRIVE_FAST;
                // a line leaves the timer armed for reverse
                if (line) begin
                    seq_mode = MODE_REVERSE;
                end else if (timer_expired(now, cfg_center_time)) begin
                    seq_left  = DRIVE_STOP;
                    seq_right = DRIVE_STOP;
                    seq_mode  = (near_l && near_r) ? MODE_CHASE : MODE_SEARCH;
                end
            end
            MODE_STALL: begin
                seq_left   = DRIVE_STOP;
                seq_right  = DRIVE_STOP;
                seq_magnet = 1'b1;
            end
            MODE_SEARCH: begin
                if (line) begin
                    seq_mode = MODE_STALL;
                end else if (near_l && near_r) begin
                    seq_mode = MODE_CHASE;
                end else begin
                    if (near_r) turn_right = 1'b1;
                    else if (near_l) turn_right = 1'b0;
                    seq_left  = turn_right ? DRIVE_TURN : -DRIVE_TURN;
                    seq_right = turn_right ? -DRIVE_TURN : DRIVE_TURN;
                end
            end
            MODE_REVERSE: begin
                seq_left  = DRIVE_BACK;
                seq_right = DRIVE_BACK;
                if (timer_expired(now, cfg_reverse_time)) begin
                    seq_left  = DRIVE_STOP;
                    seq_right = DRIVE_STOP;
                    seq_mode  = MODE_SEARCH;
                end
            end
            MODE_CHASE: begin
                seq_left  = DRIVE_FAST;
                seq_right = DRIVE_FAST;
                if (line) seq_mode = MODE_REVERSE;
                else if (!near_l || !near_r) seq_mode = MODE_SEARCH;
            end
            default: ;
        endcase
    endfunction

    // valid is left high on return; the next request or the caller lowers it
    task automatic send_tick(input logic [31:0] now, input logic line_a, input logic line_b,
                             input logic [9:0] dist_l, input logic [9:0] dist_r);
        int gap;
        gap = (idle_bursts && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_now_ms       <= now;
        i_line_front_a <= line_a;
        i_line_front_b <= line_b;
        i_dist_left    <= dist_l;
        i_dist_right   <= dist_r;
        do @(posedge i_clk); while (!o_ready);
        advance_sequencer(now, line_a | line_b, dist_l, dist_r);
        expected_drive.push_back(t_drive_state'{seq_left, seq_right, seq_magnet, seq_mode});
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        i_valid <= 1'b0;
        while (expected_drive.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            REG_START_DELAY:  cfg_start_delay  = value;
            REG_REVERSE_TIME: cfg_reverse_time = value;
            REG_CENTER_TIME:  cfg_center_time  = value;
            REG_DETECT_RANGE: cfg_detect_range = value[9:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [9:0] pick_distance();
        if (cfg_detect_range != 0 && $urandom_range(0, 1) == 1)
            return 10'($urandom_range(0, cfg_detect_range - 1));
        return 10'($urandom_range(0, 1023));
    endfunction

    // lines are kept out of search so the run does not drop into stall early
    task automatic send_random_tick();
        int          step_max;
        logic [1:0]  lines;
        logic [9:0]  dist_l;
        logic [9:0]  dist_r;
        step_max = (cfg_reverse_time >> 2) + 2;
        if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, step_max);
        dist_l = pick_distance();
        dist_r = pick_distance();
        lines  = 2'b00;
        if (seq_mode != MODE_SEARCH && $urandom_range(0, 4) == 0)
            lines = 2'($urandom_range(1, 3));
        send_tick(clock_ms, lines[0], lines[1], dist_l, dist_r);
    endtask

    task automatic test_start_and_center();
        // start wait: exactly the delay does not fire, one more does
        send_tick(32'd1000, 1'b0, 1'b0, 10'd1023, 10'd1023);
        send_tick(32'd1500, 1'b0, 1'b0, 10'd1023, 10'd1023);
        send_tick(32'd1501, 1'b0, 1'b0, 10'd1023, 10'd1023);
        // center arms, then leaves on a line with the timer still running
        send_tick(32'd1600, 1'b0, 1'b0, 10'd1023, 10'd1023);
        send_tick(32'd1700, 1'b1, 1'b0, 10'd0, 10'd0);
        // reverse fires at once on the begin time taken in center
        send_tick(32'd2101, 1'b0, 1'b1, 10'd0, 10'd0);
    endtask

    task automatic test_search_and_chase();
        send_tick(32'd3000, 1'b0, 1'b0, 10'd1023, 10'd29);
        send_tick(32'd3010, 1'b0, 1'b0, 10'd30, 10'd30);
        send_tick(32'd3020, 1'b0, 1'b0, 10'd29, 10'd30);
        send_tick(32'd3030, 1'b0, 1'b0, 10'd512, 10'd1023);
        send_tick(32'd3040, 1'b0, 1'b0, 10'd0, 10'd0);
        send_tick(32'd3050, 1'b0, 1'b0, 10'd0, 10'd29);
        send_tick(32'd3060, 1'b0, 1'b0, 10'd30, 10'd0);
        send_tick(32'd3070, 1'b0, 1'b0, 10'd29, 10'd29);
        send_tick(32'd3080, 1'b0, 1'b1, 10'd1023, 10'd1023);
    endtask

    task automatic test_reverse_timer();
        send_tick(32'd5000, 1'b0, 1'b0, 10'd0, 10'd0);
        send_tick(32'd5500, 1'b0, 1'b0, 10'd0, 10'd0);
        send_tick(32'd5501, 1'b0, 1'b0, 10'd0, 10'd0);
        send_tick(32'd5600, 1'b0, 1'b0, 10'd0, 10'd0);
        send_tick(32'd5700, 1'b1, 1'b1, 10'd0, 10'd0);
        // wait spanning the 32-bit wrap of the time stamp
        send_tick(32'hFFFF_FF00, 1'b0, 1'b0, 10'd1023, 10'd1023);
        send_tick(32'h0000_00F4, 1'b0, 1'b0, 10'd1023, 10'd1023);
        send_tick(32'h0000_00F5, 1'b0, 1'b0, 10'd1023, 10'd1023);
        clock_ms = 32'h0000_00F5;
    endtask

    task automatic test_output_backpressure();
        hold_cycles = 120;
        repeat (60) send_random_tick();
    endtask

    task automatic test_register_sweep();
        logic [15:0] setting [4];
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: setting = '{16'd0, 16'd0, 16'd0, 16'd0};
                1: setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                2: setting = '{START_DELAY_RST, REVERSE_TIME_RST, CENTER_TIME_RST,
                               {6'd0, DETECT_RANGE_RST}};
                3: setting = '{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
                default: setting = '{16'($urandom_range(0, 20)), 16'($urandom_range(1, 20)),
                                     16'($urandom_range(0, 20)),
                                     16'($urandom_range(100, 600))};
            endcase
            write_register(REG_START_DELAY,  setting[0]);
            write_register(REG_REVERSE_TIME, setting[1]);
            write_register(REG_CENTER_TIME,  setting[2]);
            write_register(REG_DETECT_RANGE, setting[3]);
            idle_bursts = (phase != 4);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (phase != 4 && n % 60 == 0) idle_bursts = ($urandom_range(0, 2) != 0);
                send_random_tick();
            end
        end
    endtask

    // stall only ends with reset, so it comes last
    task automatic test_stall_and_magnet();
        while (seq_mode != MODE_SEARCH) begin
            clock_ms += 32'd70000;
            send_tick(clock_ms, 1'b0, 1'b0, 10'd1023, 10'd1023);
        end
        send_tick(clock_ms, 1'b1, 1'b1, 10'd0, 10'd0);
        repeat (8) begin
            send_tick($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        end
    endtask

    initial begin : result_receiver
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                i_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                i_ready <= 1'b1;
            end else if (idle_bursts && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_drive_state want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_drive.size() == 0) begin
                flag_error($sformatf("unexpected result, mode %0d", o_mode_now));
            end else begin
                want = expected_drive.pop_front();
                if (o_drive_left !== want.drv_left)
                    flag_error($sformatf("drive_left %0d, want %0d", o_drive_left,
                                         want.drv_left));
                if (o_drive_right !== want.drv_right)
                    flag_error($sformatf("drive_right %0d, want %0d", o_drive_right,
                                         want.drv_right));
                if (o_magnet_on !== want.magnet)
                    flag_error($sformatf("magnet_on %0b, want %0b", o_magnet_on, want.magnet));
                if (o_mode_now !== want.mode)
                    flag_error($sformatf("mode_now %0d, want %0d", o_mode_now, want.mode));
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_now_ms       = 32'd0;
        i_line_front_a = 1'b0;
        i_line_front_b = 1'b0;
        i_dist_left    = 10'd0;
        i_dist_right   = 10'd0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = REG_START_DELAY;
        i_cfg_data     = 16'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_start_and_center();
        test_search_and_chase();
        test_reverse_timer();
        test_output_backpressure();
        test_register_sweep();
        test_stall_and_magnet();

        i_valid <= 1'b0;
        while (expected_drive.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
src/rms_pkg.sv
src/rms_core.sv
src/robot_mode_sequencer.sv
sim/robot_mode_sequencer_test.sv
